FILE: rtl/u8rb_pkg.sv
package u8rb_pkg;

  localparam int unsigned MaxOut = 6;

  // validate_mode codes; bit 1 set means mark mode (code 3 included)
  localparam logic [1:0] ModeOff    = 2'd0;
  localparam logic [1:0] ModeRepair = 2'd1;
  localparam logic [1:0] ModeMark   = 2'd2;
  localparam int unsigned MarkBit   = 1;

  localparam logic [7:0] ReplByte0 = 8'hEF;
  localparam logic [7:0] ReplByte1 = 8'hBF;
  localparam logic [7:0] ReplByte2 = 8'hBD;
  localparam logic [7:0] BomByte0  = 8'hEF;
  localparam logic [7:0] BomByte1  = 8'hBB;
  localparam logic [7:0] BomByte2  = 8'hBF;
  localparam logic [7:0] ContLo    = 8'h80;
  localparam logic [7:0] ContHi    = 8'hBF;

  typedef struct packed {
    logic [2:0][7:0] held;
    logic [1:0]      cnt;
    logic [2:0]      len;
    logic [7:0]      lo;
    logic [7:0]      hi;
    logic            at_start;
    logic            bad;
  } scan_state_t;

  // all results of one input item
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [2:0]             cnt;
    logic                   present;
    logic                   last;
    logic                   invalid;
  } out_group_t;

  typedef struct packed {
    scan_state_t            st;
    logic [MaxOut-1:0][7:0] bytes;
    logic [2:0]             n;
  } step_t;

  typedef struct packed {
    logic       lead;
    logic [2:0] len;
    logic [7:0] lo;
    logic [7:0] hi;
  } lead_info_t;

  function automatic lead_info_t classify_lead(logic [7:0] b);
    lead_info_t li;
    li.lead = 1'b1;
    li.len  = 3'd0;
    li.lo   = ContLo;
    li.hi   = ContHi;
    if (b >= 8'hC2 && b <= 8'hDF) begin
      li.len = 3'd2;
    end else if (b == 8'hE0) begin
      li.len = 3'd3;
      li.lo  = 8'hA0;
    end else if (b == 8'hED) begin
      li.len = 3'd3;
      li.hi  = 8'h9F;
    end else if (b >= 8'hE1 && b <= 8'hEF) begin
      li.len = 3'd3;
    end else if (b == 8'hF0) begin
      li.len = 3'd4;
      li.lo  = 8'h90;
    end else if (b >= 8'hF1 && b <= 8'hF3) begin
      li.len = 3'd4;
    end else if (b == 8'hF4) begin
      li.len = 3'd4;
      li.hi  = 8'h8F;
    end else begin
      li.lead = 1'b0;
    end
    return li;
  endfunction

  function automatic step_t emit_byte(step_t w, logic [7:0] b);
    w.bytes[w.n] = b;
    w.n = w.n + 3'd1;
    return w;
  endfunction

  function automatic step_t emit_repl(step_t w);
    w = emit_byte(w, ReplByte0);
    w = emit_byte(w, ReplByte1);
    w = emit_byte(w, ReplByte2);
    return w;
  endfunction

  function automatic step_t emit_held(step_t w);
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < w.st.cnt) begin
        w = emit_byte(w, w.st.held[i]);
      end
    end
    return w;
  endfunction

  function automatic scan_state_t clear_held(scan_state_t s);
    s.cnt = 2'd0;
    s.len = 3'd0;
    s.lo  = ContLo;
    s.hi  = ContHi;
    return s;
  endfunction

  // held prefix ends as one ill-formed subpart
  function automatic step_t flush_bad(step_t w, logic repair);
    w.st.bad = 1'b1;
    if (repair) begin
      w = emit_repl(w);
    end else begin
      w = emit_held(w);
    end
    w.st = clear_held(w.st);
    w.st.at_start = 1'b0;
    return w;
  endfunction

endpackage

FILE: rtl/u8rb_front.sv
module u8rb_front import u8rb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] mode_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       has_byte_i,
  input  logic       source_is_8bit_i,
  input  logic       end_of_record_i,
  input  logic       q_full_i,
  output logic       push_o,
  output out_group_t group_o
);

  localparam scan_state_t StReset = '{held: '0, cnt: 2'd0, len: 3'd0, lo: ContLo,
                                      hi: ContHi, at_start: 1'b1, bad: 1'b0};

  scan_state_t st_q, st_d;
  step_t       w;
  lead_info_t  li;
  logic        repair, mark, taken, bom, accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign repair     = (mode_i == ModeRepair);
  assign mark       = mode_i[MarkBit];
  assign li         = classify_lead(data_byte_i);

  always_comb begin
    w.st    = st_q;
    w.bytes = '0;
    w.n     = 3'd0;
    taken   = 1'b0;
    bom     = 1'b0;
    group_o = '0;

    if (has_byte_i) begin
      if (source_is_8bit_i) begin
        if (w.st.cnt != 2'd0) begin
          w = flush_bad(w, repair);
        end
        if (!data_byte_i[7]) begin
          w = emit_byte(w, data_byte_i);
        end else begin
          w = emit_repl(w);
        end
        w.st.at_start = 1'b0;
      end else begin
        if (w.st.cnt != 2'd0) begin
          if (data_byte_i >= w.st.lo && data_byte_i <= w.st.hi) begin
            taken = 1'b1;
            if (({1'b0, w.st.cnt} + 3'd1) >= w.st.len) begin
              bom = w.st.at_start && (w.st.len == 3'd3) &&
                    (w.st.held[0] == BomByte0) && (w.st.held[1] == BomByte1) &&
                    (data_byte_i == BomByte2);
              if (!bom) begin
                w = emit_held(w);
                w = emit_byte(w, data_byte_i);
              end
              w.st          = clear_held(w.st);
              w.st.at_start = 1'b0;
            end else begin
              w.st.held[w.st.cnt] = data_byte_i;
              w.st.cnt            = w.st.cnt + 2'd1;
              w.st.lo             = ContLo;
              w.st.hi             = ContHi;
            end
          end else begin
            w = flush_bad(w, repair);
          end
        end
        if (!taken) begin
          if (!data_byte_i[7]) begin
            w = emit_byte(w, data_byte_i);
            w.st.at_start = 1'b0;
          end else if (li.lead) begin
            w.st.held[0] = data_byte_i;
            w.st.cnt     = 2'd1;
            w.st.len     = li.len;
            w.st.lo      = li.lo;
            w.st.hi      = li.hi;
          end else begin
            w.st.bad = 1'b1;
            if (repair) begin
              w = emit_repl(w);
            end else begin
              w = emit_byte(w, data_byte_i);
            end
            w.st.at_start = 1'b0;
          end
        end
      end
    end

    group_o.present = 1'b1;
    if (end_of_record_i) begin
      if (w.st.cnt != 2'd0) begin
        w = flush_bad(w, repair);
      end
      if (w.n == 3'd0) begin
        // empty record marker
        w.n             = 3'd1;
        group_o.present = 1'b0;
      end
      group_o.last    = 1'b1;
      group_o.invalid = mark && w.st.bad;
      w.st            = clear_held(w.st);
      w.st.at_start   = 1'b1;
      w.st.bad        = 1'b0;
    end
    group_o.bytes = w.bytes;
    group_o.cnt   = w.n;
  end

  assign push_o = accept && (w.n != 3'd0);
  assign st_d   = accept ? w.st : st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StReset;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

FILE: rtl/u8rb_queue.sv
module u8rb_queue import u8rb_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  out_group_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output out_group_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  out_group_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/u8rb_back.sv
module u8rb_back import u8rb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  out_group_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_present_o,
  output logic       last_of_record_o,
  output logic       record_invalid_o
);

  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q;
  logic       present_q, last_q, invalid_q;
  logic       load, last_byte;

  assign load      = head_valid_i && (!out_valid_q || !out_stall_i);
  assign last_byte = (idx_q == (head_i.cnt - 3'd1));
  assign pop_o     = load && last_byte;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = last_byte ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q    <= head_i.bytes[idx_q];
      present_q <= head_i.present;
      last_q    <= head_i.last && last_byte;
      invalid_q <= head_i.invalid && last_byte;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = byte_q;
  assign byte_present_o   = present_q;
  assign last_of_record_o = last_q;
  assign record_invalid_o = invalid_q;

endmodule

FILE: rtl/utf8_repair_and_bom_strip.sv
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  data_byte, has_byte, source_is_8bit, end_of_record
// out      output     out_valid_o / out_stall_i out_byte, byte_present, last_of_record,
//                                                record_invalid
// cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (validate_mode)
//
// The front scans one byte per cycle unless the queue is full, and hands its 0..6 result
// bytes as one group to a queue of QueueDepth groups; the back drains one byte per cycle
// while out_stall_i is low. An item producing k bytes holds the output port for k
// transfers; the queue refills the front's headroom, so unstalled single-byte items flow
// at one per cycle. Results pass through the queue and the back's output register.
// Reset clears the scan state, the queue and validate_mode (off); cfg is always ready.
module utf8_repair_and_bom_strip import u8rb_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       has_byte_i,
  input  logic       source_is_8bit_i,
  input  logic       end_of_record_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_present_o,
  output logic       last_of_record_o,
  output logic       record_invalid_o
);

  logic [1:0] mode_q;
  logic       push, pop, q_full, head_valid;
  out_group_t push_group, head_group;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeOff;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  u8rb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mode_i           (mode_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .has_byte_i       (has_byte_i),
    .source_is_8bit_i (source_is_8bit_i),
    .end_of_record_i  (end_of_record_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .group_o          (push_group)
  );

  u8rb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_group),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_group)
  );

  u8rb_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_i           (head_group),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .byte_present_o   (byte_present_o),
    .last_of_record_o (last_of_record_o),
    .record_invalid_o (record_invalid_o)
  );

endmodule

FILE: tb/utf8_repair_and_bom_strip_test.sv
typedef struct packed {
  logic [7:0] value;
  logic       present;
  logic       last;
  logic       invalid;
} text_beat_t;

class utf8_scoreboard;
  logic [1:0]  mode;
  logic [7:0]  held [3];
  logic [1:0]  held_n;
  logic [2:0]  seq_len;
  logic [7:0]  cont_lo;
  logic [7:0]  cont_hi;
  bit          rec_start;
  bit          rec_bad;
  text_beat_t  item_beats[$];
  text_beat_t  expected_beats[$];
  int unsigned errors;
  int unsigned items;
  int unsigned records;
  int unsigned beats_checked;
  int unsigned repl_count;
  int unsigned flagged;

  function new();
    mode = u8rb_pkg::ModeOff;
    foreach (held[i]) held[i] = 8'h00;
    drop_held();
    rec_start = 1'b1;
    rec_bad = 1'b0;
  endfunction

  function int unsigned pending();
    return expected_beats.size();
  endfunction

  function void push_byte(input logic [7:0] b);
    text_beat_t beat;
    if (item_beats.size() >= u8rb_pkg::MaxOut) return;
    beat.value = b;
    beat.present = 1'b1;
    beat.last = 1'b0;
    beat.invalid = 1'b0;
    item_beats.push_back(beat);
  endfunction

  function void push_repl();
    repl_count++;
    push_byte(u8rb_pkg::ReplByte0);
    push_byte(u8rb_pkg::ReplByte1);
    push_byte(u8rb_pkg::ReplByte2);
  endfunction

  function void drop_held();
    held_n = 2'd0;
    seq_len = 3'd0;
    cont_lo = u8rb_pkg::ContLo;
    cont_hi = u8rb_pkg::ContHi;
  endfunction

  // held prefix counts as one bad subpart
  function void end_bad();
    rec_bad = 1'b1;
    if (mode == u8rb_pkg::ModeRepair) begin
      push_repl();
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (i < held_n) push_byte(held[i]);
      end
    end
    drop_held();
    rec_start = 1'b0;
  endfunction

  function void begin_seq(input logic [7:0] b, input logic [2:0] len,
                          input logic [7:0] lo, input logic [7:0] hi);
    held[0] = b;
    held_n = 2'd1;
    seq_len = len;
    cont_lo = lo;
    cont_hi = hi;
  endfunction

  function void lead_byte(input logic [7:0] b);
    if (b < 8'h80) begin
      push_byte(b);
      rec_start = 1'b0;
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      begin_seq(b, 3'd2, 8'h80, 8'hBF);
    end else if (b == 8'hE0) begin
      begin_seq(b, 3'd3, 8'hA0, 8'hBF);
    end else if (b == 8'hED) begin
      begin_seq(b, 3'd3, 8'h80, 8'h9F);
    end else if (b >= 8'hE1 && b <= 8'hEF) begin
      begin_seq(b, 3'd3, 8'h80, 8'hBF);
    end else if (b == 8'hF0) begin
      begin_seq(b, 3'd4, 8'h90, 8'hBF);
    end else if (b >= 8'hF1 && b <= 8'hF3) begin
      begin_seq(b, 3'd4, 8'h80, 8'hBF);
    end else if (b == 8'hF4) begin
      begin_seq(b, 3'd4, 8'h80, 8'h8F);
    end else begin
      rec_bad = 1'b1;
      if (mode == u8rb_pkg::ModeRepair) push_repl();
      else push_byte(b);
      rec_start = 1'b0;
    end
  endfunction

  function void utf8_byte(input logic [7:0] b);
    bit bom;
    if (held_n != 2'd0) begin
      if (b >= cont_lo && b <= cont_hi) begin
        if ({1'b0, held_n} + 3'd1 >= seq_len) begin
          bom = rec_start && seq_len == 3'd3 && held[0] == u8rb_pkg::BomByte0 &&
                held[1] == u8rb_pkg::BomByte1 && b == u8rb_pkg::BomByte2;
          if (!bom) begin
            for (int i = 0; i < 3; i++) begin
              if (i < held_n) push_byte(held[i]);
            end
            push_byte(b);
          end
          drop_held();
          rec_start = 1'b0;
        end else begin
          held[held_n] = b;
          held_n = held_n + 2'd1;
          cont_lo = u8rb_pkg::ContLo;
          cont_hi = u8rb_pkg::ContHi;
        end
        return;
      end
      end_bad();
    end
    lead_byte(b);
  endfunction

  function void note_transfer(input logic [7:0] b, input logic has, input logic is8,
                              input logic eor);
    text_beat_t beat;
    item_beats.delete();
    if (has || eor) items++;
    if (has) begin
      if (is8) begin
        if (held_n != 2'd0) end_bad();
        if (b < 8'h80) push_byte(b);
        else push_repl();
        rec_start = 1'b0;
      end else begin
        utf8_byte(b);
      end
    end
    if (eor) begin
      if (held_n != 2'd0) end_bad();
      if (item_beats.size() == 0) begin
        beat = '0;
      end else begin
        beat = item_beats.pop_back();
      end
      beat.last = 1'b1;
      beat.invalid = mode[u8rb_pkg::MarkBit] && rec_bad;
      if (beat.invalid) flagged++;
      item_beats.push_back(beat);
      drop_held();
      rec_start = 1'b1;
      rec_bad = 1'b0;
      records++;
    end
    foreach (item_beats[i]) expected_beats.push_back(item_beats[i]);
  endfunction

  function void check_transfer(input text_beat_t got);
    text_beat_t want;
    if (expected_beats.size() == 0) begin
      $error("unexpected result: out_byte %h byte_present %b last_of_record %b record_invalid %b",
             got.value, got.present, got.last, got.invalid);
      errors++;
      return;
    end
    want = expected_beats.pop_front();
    beats_checked++;
    if (got.value !== want.value) begin
      $error("out_byte: expected %h, actual %h", want.value, got.value);
      errors++;
    end
    if (got.present !== want.present) begin
      $error("byte_present: expected %b, actual %b", want.present, got.present);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last_of_record: expected %b, actual %b", want.last, got.last);
      errors++;
    end
    if (got.invalid !== want.invalid) begin
      $error("record_invalid: expected %b, actual %b", want.invalid, got.invalid);
      errors++;
    end
  endfunction
endclass

module utf8_repair_and_bom_strip_test;
  import u8rb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned TimeoutCycles = 200_000;
  localparam int unsigned PhaseItems    = 14;
  // spare code, decoded as mark
  localparam logic [1:0]  ModeMarkAlt   = 2'd3;

  typedef enum int {StallNone, StallCoin, StallHeavy, StallPeriodic} stall_style_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data = ModeOff;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       has_byte = 1'b0;
  logic       source_is_8bit = 1'b0;
  logic       end_of_record = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       last_of_record;
  logic       record_invalid;

  utf8_scoreboard sb = new();

  int unsigned  items_sent = 0;
  int unsigned  burst_left = 0;
  int unsigned  stall_left = 0;
  int unsigned  cycle_n = 0;
  stall_style_e stall_style = StallNone;

  logic [7:0] rec_bytes[$];
  bit         rec_8bit[$];

  utf8_repair_and_bom_strip uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (data_byte),
    .has_byte_i       (has_byte),
    .source_is_8bit_i (source_is_8bit),
    .end_of_record_i  (end_of_record),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_byte_o       (out_byte),
    .byte_present_o   (byte_present),
    .last_of_record_o (last_of_record),
    .record_invalid_o (record_invalid)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  always @(posedge clk) begin
    text_beat_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_transfer(data_byte, has_byte, source_is_8bit, end_of_record);
      end
      if (out_valid && !out_stall) begin
        got.value = out_byte;
        got.present = byte_present;
        got.last = last_of_record;
        got.invalid = record_invalid;
        sb.check_transfer(got);
      end
    end
  end

  // receiver back-pressure, style is redrawn whenever its random countdown runs out
  always @(posedge clk) begin
    cycle_n++;
    if (stall_left == 0) begin
      stall_style = stall_style_e'($urandom_range(3, 0));
      stall_left = $urandom_range(96, 16);
    end else begin
      stall_left--;
    end
    case (stall_style)
      StallNone:  out_stall <= 1'b0;
      StallCoin:  out_stall <= 1'($urandom_range(1, 0));
      StallHeavy: out_stall <= ($urandom_range(3, 0) != 0);
      default:    out_stall <= ((cycle_n % 5) < 2);
    endcase
  end

  function automatic logic [7:0] pick(input logic [7:0] lo, input logic [7:0] hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic void add_byte(input logic [7:0] b, input bit is8);
    rec_bytes.push_back(b);
    rec_8bit.push_back(is8);
  endfunction

  // one well-formed character of the given length
  function automatic void add_char(input int unsigned len);
    logic [7:0] lead;
    case (len)
      1: add_byte(pick(8'h00, 8'h7F), 1'b0);
      2: begin
        add_byte(pick(8'hC2, 8'hDF), 1'b0);
        add_byte(pick(8'h80, 8'hBF), 1'b0);
      end
      3: begin
        lead = pick(8'hE0, 8'hEF);
        add_byte(lead, 1'b0);
        if (lead == 8'hE0) add_byte(pick(8'hA0, 8'hBF), 1'b0);
        else if (lead == 8'hED) add_byte(pick(8'h80, 8'h9F), 1'b0);
        else add_byte(pick(8'h80, 8'hBF), 1'b0);
        add_byte(pick(8'h80, 8'hBF), 1'b0);
      end
      default: begin
        lead = pick(8'hF0, 8'hF4);
        add_byte(lead, 1'b0);
        if (lead == 8'hF0) add_byte(pick(8'h90, 8'hBF), 1'b0);
        else if (lead == 8'hF4) add_byte(pick(8'h80, 8'h8F), 1'b0);
        else add_byte(pick(8'h80, 8'hBF), 1'b0);
        add_byte(pick(8'h80, 8'hBF), 1'b0);
        add_byte(pick(8'h80, 8'hBF), 1'b0);
      end
    endcase
  endfunction

  task automatic send_item(input logic [7:0] b, input logic has, input logic is8,
                           input logic eor);
    int unsigned gap;
    in_valid <= 1'b1;
    data_byte <= b;
    has_byte <= has;
    source_is_8bit <= is8;
    end_of_record <= eor;
    do @(posedge clk); while (in_stall);
    if (has || eor) items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(16, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_mode(input logic [1:0] m);
    wait_drained();
    // items with no output may still be in flight
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    sb.mode = m;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_record();
    int unsigned kind;
    int unsigned n;
    int unsigned idx;
    bit          split_end;
    rec_bytes.delete();
    rec_8bit.delete();
    kind = $urandom_range(99, 0);
    n = $urandom_range(4, 1);
    if (kind < 55) begin
      if ($urandom_range(4, 0) == 0) begin
        add_byte(BomByte0, 1'b0);
        add_byte(BomByte1, 1'b0);
        add_byte(BomByte2, 1'b0);
      end
      repeat (n) add_char($urandom_range(4, 1));
    end else if (kind < 70) begin
      // damaged text: cut tail or one corrupted byte
      if ($urandom_range(2, 0) == 0) begin
        add_byte(BomByte0, 1'b0);
        add_byte(BomByte1, 1'b0);
      end
      repeat (n) add_char($urandom_range(4, 2));
      if ($urandom_range(1, 0) == 0) begin
        void'(rec_bytes.pop_back());
        void'(rec_8bit.pop_back());
      end else begin
        idx = $urandom_range(rec_bytes.size() - 1, 0);
        rec_bytes[idx] = pick(8'h00, 8'hFF);
      end
    end else if (kind < 82) begin
      repeat (n) add_byte(pick(8'h00, 8'hFF), 1'b1);
    end else if (kind < 94) begin
      repeat (n + 2) add_byte(pick(8'h00, 8'hFF), 1'($urandom_range(1, 0)));
    end
    split_end = (rec_bytes.size() == 0) || ($urandom_range(4, 0) == 0);
    foreach (rec_bytes[i]) begin
      if ($urandom_range(19, 0) == 0) begin
        send_item(pick(8'h00, 8'hFF), 1'b0, 1'($urandom_range(1, 0)), 1'b0);
      end
      send_item(rec_bytes[i], 1'b1, rec_8bit[i],
                !split_end && (i == rec_bytes.size() - 1));
    end
    if (split_end) send_item(pick(8'h00, 8'hFF), 1'b0, 1'($urandom_range(1, 0)), 1'b1);
  endtask

  initial begin
    logic [1:0]  phase_modes [6];
    int unsigned quota;
    phase_modes = '{ModeMarkAlt, ModeOff, ModeRepair, ModeMark, ModeRepair, ModeOff};
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(ModeRepair);
    // mark at the start of a record is dropped
    send_item(BomByte0, 1'b1, 1'b0, 1'b0);
    send_item(BomByte1, 1'b1, 1'b0, 1'b0);
    send_item(BomByte2, 1'b1, 1'b0, 1'b0);
    send_item(8'h41, 1'b1, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1, 1'b1);
    // truncated four-byte tail
    send_item(8'hF0, 1'b1, 1'b0, 1'b0);
    send_item(8'h90, 1'b1, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b0, 1'b1);
    // E0 needs A0..BF; the stray 80 then fails on its own
    send_item(8'hE0, 1'b1, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b0, 1'b1);
    // 8-bit byte cuts a held UTF-8 prefix
    send_item(8'hE2, 1'b1, 1'b0, 1'b0);
    send_item(8'h41, 1'b1, 1'b1, 1'b1);
    send_item(8'hF4, 1'b1, 1'b0, 1'b0);
    send_item(8'h8F, 1'b1, 1'b0, 1'b0);
    send_item(8'hBF, 1'b1, 1'b0, 1'b0);
    send_item(8'hBF, 1'b1, 1'b0, 1'b0);
    send_item(8'hC0, 1'b1, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0, 1'b1);
    // mode switch while a prefix is held
    send_item(8'hE2, 1'b1, 1'b0, 1'b0);
    send_item(8'h82, 1'b1, 1'b0, 1'b0);
    write_mode(ModeMark);
    send_item(8'h41, 1'b1, 1'b0, 1'b1);

    foreach (phase_modes[p]) begin
      write_mode(phase_modes[p]);
      quota = items_sent + PhaseItems;
      while (items_sent < quota) begin
        send_random_record();
        if ($urandom_range(19, 0) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (SettleCycles * 2) @(posedge clk);
    $display("Covered %0d items in %0d records with all four mode codes; %0d result bytes checked,",
             sb.items, sb.records, sb.beats_checked);
    $display("%0d replacement characters predicted, %0d records flagged ill-formed in mark mode",
             sb.repl_count, sb.flagged);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
rtl/u8rb_pkg.sv
rtl/u8rb_front.sv
rtl/u8rb_queue.sv
rtl/u8rb_back.sv
rtl/utf8_repair_and_bom_strip.sv
tb/utf8_repair_and_bom_strip_test.sv
